// File: design/ilp_pkg.sv
// Shared types, constants and helpers for the integer literal parser.
package ilp_pkg;

    // Digit run limit and counter sizing
    localparam int MAX_RUN = 100;
    localparam int RUN_W   = 7;
    localparam logic [RUN_W-1:0] RUN_SAT   = '1;
    localparam logic [RUN_W-1:0] RUN_LIMIT = RUN_W'(MAX_RUN - 1);

    // Token queue sizing
    localparam int Q_DEPTH = 2;
    localparam int Q_AW    = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);

    // Type limits
    localparam logic [63:0] S32_MAX = 64'h0000_0000_7FFF_FFFF;
    localparam logic [63:0] U32_MAX = 64'h0000_0000_FFFF_FFFF;
    localparam logic [63:0] S64_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] U64_MAX = 64'hFFFF_FFFF_FFFF_FFFF;

    // Character codes
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LF    = 8'h66;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UF    = 8'h46;
    localparam logic [7:0] CH_QUOTE = 8'h27;
    localparam logic [7:0] CH_LX    = 8'h78;
    localparam logic [7:0] CH_UX    = 8'h58;
    localparam logic [7:0] CH_LB    = 8'h62;
    localparam logic [7:0] CH_UB    = 8'h42;
    localparam logic [7:0] CH_LU    = 8'h75;
    localparam logic [7:0] CH_UU    = 8'h55;
    localparam logic [7:0] CH_LZ    = 8'h7A;
    localparam logic [7:0] CH_UZ    = 8'h5A;
    localparam logic [7:0] CH_LL    = 8'h6C;
    localparam logic [7:0] CH_UL    = 8'h4C;

    localparam logic [4:0] HEX_NONE = 5'd16;
    localparam logic [3:0] DIG_TEN  = 4'd10;

    typedef enum logic [1:0] {
        RX_DEC = 2'd0,
        RX_HEX = 2'd1,
        RX_BIN = 2'd2,
        RX_OCT = 2'd3
    } t_radix;

    typedef enum logic [3:0] {
        OP_NONE       = 4'd0,
        OP_ZERO_START = 4'd1,
        OP_PREFIX     = 4'd2,
        OP_DIGIT      = 4'd3,
        OP_BAD_DIGIT  = 4'd4,
        OP_QUOTE      = 4'd5,
        OP_SUF_U      = 4'd6,
        OP_SUF_Z      = 4'd7,
        OP_SUF_L      = 4'd8
    } t_op;

    typedef enum logic [1:0] {
        WK_INT   = 2'd0,
        WK_LONG  = 2'd1,
        WK_LLONG = 2'd2,
        WK_SIZE  = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ERR_OK    = 2'd0,
        ERR_DIGIT = 2'd1,
        ERR_OVF   = 2'd2
    } t_err;

    // One classified character, front to back
    typedef struct packed {
        t_op        op;
        logic [3:0] digit;
        t_radix     radix;
        logic       last;
    } t_tok;

    // Hex digit value, HEX_NONE when the character is not a hex digit
    function automatic logic [4:0] hex_val(input logic [7:0] c);
        logic [4:0] v;
        if (c >= CH_0 && c <= CH_9) begin
            v = 5'(c - CH_0);
        end else if (c >= CH_LA && c <= CH_LF) begin
            v = 5'(c - CH_LA) + 5'(DIG_TEN);
        end else if (c >= CH_UA && c <= CH_UF) begin
            v = 5'(c - CH_UA) + 5'(DIG_TEN);
        end else begin
            v = HEX_NONE;
        end
        return v;
    endfunction

    // Suffix letter to operation
    function automatic t_op suffix_op(input logic [7:0] c);
        t_op op;
        if (c == CH_LU || c == CH_UU) begin
            op = OP_SUF_U;
        end else if (c == CH_LZ || c == CH_UZ) begin
            op = OP_SUF_Z;
        end else if (c == CH_LL || c == CH_UL) begin
            op = OP_SUF_L;
        end else begin
            op = OP_NONE;
        end
        return op;
    endfunction

endpackage

// File: design/ilp_intf.sv
// Channel interfaces: character input and parse result output.
interface ilp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;
    logic       last;

    modport source (output valid, ch, last, input ready);
    modport sink   (input valid, ch, last, output ready);
    modport mon    (input valid, ch, last, ready);
endinterface

interface ilp_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] value;
    logic        is_unsig;
    logic [1:0]  width_kind;
    logic [1:0]  err_code;

    modport source (output valid, value, is_unsig, width_kind, err_code, input ready);
    modport sink   (input valid, value, is_unsig, width_kind, err_code, output ready);
    modport mon    (input valid, value, is_unsig, width_kind, err_code, ready);
endinterface

// File: design/ilp_front.sv
// Front end: tracks prefix phase and base, classifies each character into a token.
module ilp_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    ilp_in_if.sink        i_in,
    output logic          o_tok_valid,
    output ilp_pkg::t_tok o_tok,
    input  logic          i_tok_ready
);
    import ilp_pkg::*;

    typedef enum logic [3:0] {
        PH_FIRST  = 4'b0001,
        PH_ZERO   = 4'b0010,
        PH_RUN    = 4'b0100,
        PH_SUFFIX = 4'b1000
    } t_phase;

    t_phase     r_phase, n_phase;
    t_radix     r_radix, n_radix;
    t_op        w_op;
    logic [4:0] w_hv;
    logic       w_beat;

    // Digit not allowed in the given base
    function automatic logic digit_bad(input logic [3:0] d, input t_radix rx);
        logic bad;
        case (rx)
            RX_HEX:  bad = 1'b0;
            RX_BIN:  bad = (d > 4'd1);
            RX_OCT:  bad = (d > 4'd7);
            default: bad = (d > 4'd9);
        endcase
        return bad;
    endfunction

    assign w_hv        = hex_val(i_in.ch);
    assign w_beat      = i_in.valid & i_tok_ready;
    assign i_in.ready  = i_tok_ready;
    assign o_tok_valid = i_in.valid;

    // Classification and phase update
    always_comb begin
        n_phase = r_phase;
        n_radix = r_radix;
        w_op    = OP_NONE;
        case (r_phase)
            PH_FIRST: begin
                if (i_in.ch == CH_0) begin
                    w_op    = OP_ZERO_START;
                    n_radix = RX_OCT;
                    n_phase = PH_ZERO;
                end else begin
                    n_radix = RX_DEC;
                    n_phase = PH_RUN;
                end
            end
            PH_ZERO: begin
                n_phase = PH_RUN;
                if (i_in.ch == CH_LX || i_in.ch == CH_UX) begin
                    w_op    = OP_PREFIX;
                    n_radix = RX_HEX;
                end else if (i_in.ch == CH_LB || i_in.ch == CH_UB) begin
                    w_op    = OP_PREFIX;
                    n_radix = RX_BIN;
                end
            end
            PH_RUN: begin
            end
            PH_SUFFIX: begin
                w_op = suffix_op(i_in.ch);
            end
            default: begin
                n_phase = PH_FIRST;
                n_radix = RX_DEC;
            end
        endcase

        // Digit run character: anything that entered the run this beat
        if (n_phase == PH_RUN && w_op == OP_NONE) begin
            if (!w_hv[4]) begin
                w_op = digit_bad(w_hv[3:0], n_radix) ? OP_BAD_DIGIT : OP_DIGIT;
            end else if (i_in.ch == CH_QUOTE) begin
                w_op = OP_QUOTE;
            end else begin
                n_phase = PH_SUFFIX;
                w_op    = suffix_op(i_in.ch);
            end
        end
    end

    always_comb begin
        o_tok.op    = w_op;
        o_tok.digit = w_hv[3:0];
        o_tok.radix = n_radix;
        o_tok.last  = i_in.last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_FIRST;
            r_radix <= RX_DEC;
        end else if (w_beat) begin
            if (i_in.last) begin
                r_phase <= PH_FIRST;
                r_radix <= RX_DEC;
            end else begin
                r_phase <= n_phase;
                r_radix <= n_radix;
            end
        end
    end

endmodule

// File: design/ilp_queue.sv
// Short token queue between the front and back ends.
module ilp_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  ilp_pkg::t_tok i_tok,
    output logic          o_ready,
    output logic          o_valid,
    output ilp_pkg::t_tok o_tok,
    input  logic          i_ready
);
    import ilp_pkg::*;

    localparam logic [Q_AW-1:0] PTR_LAST = Q_AW'(Q_DEPTH - 1);
    localparam logic [Q_CW-1:0] CNT_FULL = Q_CW'(Q_DEPTH);

    t_tok            r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wp, r_rp;
    logic [Q_CW-1:0] r_cnt;
    logic            w_push, w_pop;

    assign o_ready = (r_cnt != CNT_FULL);
    assign o_valid = (r_cnt != '0);
    assign o_tok   = r_mem[r_rp];
    assign w_push  = i_valid & o_ready;
    assign w_pop   = o_valid & i_ready;

    // Storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= i_tok;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wp <= (r_wp == PTR_LAST) ? '0 : r_wp + 1'b1;
            end
            if (w_pop) begin
                r_rp <= (r_rp == PTR_LAST) ? '0 : r_rp + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

// File: design/ilp_back.sv
// Back end: accumulates digits and suffixes, checks range, holds the result register.
module ilp_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_long_wide,
    input  logic          i_tok_valid,
    input  ilp_pkg::t_tok i_tok,
    output logic          o_tok_ready,
    ilp_out_if.source     o_out
);
    import ilp_pkg::*;

    logic [63:0]      r_accum, n_accum;
    logic             r_wovf, n_wovf;
    logic             r_bad, n_bad;
    logic [RUN_W-1:0] r_run, n_run, w_run_inc;
    logic             r_u, n_u;
    logic             r_z, n_z;
    logic [1:0]       r_lcnt, n_lcnt;

    logic             r_valid;
    logic [63:0]      r_value;
    logic             r_unsig;
    t_kind            r_kind;
    t_err             r_err;

    logic [67:0]      w_ext, w_mul, w_sum;
    t_kind            w_kind;
    t_err             w_err;
    logic [63:0]      w_max;
    logic             w_take;

    // Only a final beat needs the result slot
    assign o_tok_ready = !i_tok.last || !r_valid || o_out.ready;
    assign w_take      = i_tok_valid & o_tok_ready;
    assign w_run_inc   = (r_run == RUN_SAT) ? r_run : r_run + 1'b1;

    // accum * base + digit, four spare bits show a 64-bit overflow
    always_comb begin
        w_ext = {4'b0, r_accum};
        case (i_tok.radix)
            RX_HEX:  w_mul = w_ext << 4;
            RX_BIN:  w_mul = w_ext << 1;
            RX_OCT:  w_mul = w_ext << 3;
            default: w_mul = (w_ext << 3) + (w_ext << 1);
        endcase
        w_sum = w_mul + 68'(i_tok.digit);
    end

    // Literal state update for this beat
    always_comb begin
        n_accum = r_accum;
        n_wovf  = r_wovf;
        n_bad   = r_bad;
        n_run   = r_run;
        n_u     = r_u;
        n_z     = r_z;
        n_lcnt  = r_lcnt;
        case (i_tok.op)
            OP_ZERO_START: n_run = RUN_W'(1);
            OP_PREFIX:     n_run = '0;
            OP_DIGIT: begin
                n_run = w_run_inc;
                if (!r_bad && !r_wovf) begin
                    if (|w_sum[67:64]) begin
                        n_wovf  = 1'b1;
                        n_accum = U64_MAX;
                    end else begin
                        n_accum = w_sum[63:0];
                    end
                end
            end
            OP_BAD_DIGIT: begin
                n_run = w_run_inc;
                n_bad = 1'b1;
            end
            OP_QUOTE: n_run = w_run_inc;
            OP_SUF_U: n_u = 1'b1;
            OP_SUF_Z: n_z = 1'b1;
            OP_SUF_L: begin
                if (r_lcnt < 2'd2) begin
                    n_lcnt = r_lcnt + 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    // Width kind, type maximum and error code
    always_comb begin
        if (n_lcnt == 2'd1) begin
            w_kind = WK_LONG;
        end else if (n_lcnt >= 2'd2) begin
            w_kind = WK_LLONG;
        end else if (n_z) begin
            w_kind = WK_SIZE;
        end else begin
            w_kind = WK_INT;
        end

        case (w_kind)
            WK_INT:  w_max = n_u ? U32_MAX : S32_MAX;
            WK_LONG: begin
                if (i_long_wide) begin
                    w_max = n_u ? U64_MAX : S64_MAX;
                end else begin
                    w_max = n_u ? U32_MAX : S32_MAX;
                end
            end
            default: w_max = n_u ? U64_MAX : S64_MAX;
        endcase

        if (n_run >= RUN_LIMIT) begin
            w_err = ERR_OVF;
        end else if (n_bad) begin
            w_err = ERR_DIGIT;
        end else if (n_wovf || n_accum > w_max) begin
            w_err = ERR_OVF;
        end else begin
            w_err = ERR_OK;
        end
    end

    // Literal state; cleared after the final beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_accum <= '0;
            r_wovf  <= 1'b0;
            r_bad   <= 1'b0;
            r_run   <= '0;
            r_u     <= 1'b0;
            r_z     <= 1'b0;
            r_lcnt  <= '0;
        end else if (w_take) begin
            if (i_tok.last) begin
                r_accum <= '0;
                r_wovf  <= 1'b0;
                r_bad   <= 1'b0;
                r_run   <= '0;
                r_u     <= 1'b0;
                r_z     <= 1'b0;
                r_lcnt  <= '0;
            end else begin
                r_accum <= n_accum;
                r_wovf  <= n_wovf;
                r_bad   <= n_bad;
                r_run   <= n_run;
                r_u     <= n_u;
                r_z     <= n_z;
                r_lcnt  <= n_lcnt;
            end
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_take && i_tok.last) begin
            r_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take && i_tok.last) begin
            r_value <= (w_err == ERR_OK) ? n_accum : '0;
            r_unsig <= n_u;
            r_kind  <= w_kind;
            r_err   <= w_err;
        end
    end

    assign o_out.valid      = r_valid;
    assign o_out.value      = r_value;
    assign o_out.is_unsig   = r_unsig;
    assign o_out.width_kind = r_kind;
    assign o_out.err_code   = r_err;

endmodule

// File: design/integer_literal_parser.sv
// Top level of the integer literal parser.
// Characters of a C++ integer literal arrive one beat each on i_in, with last set on
// the final one; one result beat per literal leaves on o_out from the result register
// once its last character has passed the token queue and the output is free. The block
// sustains one character per clock: the back end's accumulate step (a shift, or shift-add
// for decimal, plus a 68-bit add and range compare) retires one character each cycle.
// A two-entry token queue sits between the classifying front end and the back end,
// so i_in.ready only drops once the result register is stalled and the queue fills.
// i_cfg_wdata sets long to 64 bits (1, reset value) or 32 bits (0); write it only
// while no literal is in flight.
module integer_literal_parser (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_wdata,
    ilp_in_if.sink     i_in,
    ilp_out_if.source  o_out
);
    import ilp_pkg::*;

    logic r_long_wide;
    logic w_f_valid, w_f_ready;
    t_tok w_f_tok;
    logic w_b_valid, w_b_ready;
    t_tok w_b_tok;

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_long_wide <= 1'b1;
        end else if (i_cfg_we) begin
            r_long_wide <= i_cfg_wdata;
        end
    end

    ilp_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .o_tok_valid (w_f_valid),
        .o_tok       (w_f_tok),
        .i_tok_ready (w_f_ready)
    );

    ilp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_f_valid),
        .i_tok   (w_f_tok),
        .o_ready (w_f_ready),
        .o_valid (w_b_valid),
        .o_tok   (w_b_tok),
        .i_ready (w_b_ready)
    );

    ilp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_long_wide (r_long_wide),
        .i_tok_valid (w_b_valid),
        .i_tok       (w_b_tok),
        .o_tok_ready (w_b_ready),
        .o_out       (o_out)
    );

endmodule

// File: design/ilp_checker.sv
// Port-level checks for the integer literal parser, bound to the top level.
module ilp_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [63:0] i_out_value,
    input  logic        i_out_is_unsig,
    input  logic [1:0]  i_out_width_kind,
    input  logic [1:0]  i_out_err_code
);
    import ilp_pkg::*;

    // A reported error always carries a zero value
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_err_code != ERR_OK |-> i_out_value == '0)
        else $error("error result with nonzero value");

    // Only defined error codes leave the block
    a_err_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out_err_code == ERR_OK || i_out_err_code == ERR_DIGIT ||
                         i_out_err_code == ERR_OVF))
        else $error("undefined error code");

    // A clean signed int result is within the signed 32-bit range
    a_int_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_err_code == ERR_OK && !i_out_is_unsig &&
        i_out_width_kind == WK_INT |-> i_out_value <= S32_MAX)
        else $error("signed int result above range");

    // Stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_value) &&
        $stable(i_out_err_code))
        else $error("stalled result changed");

    // Reset leaves no result pending
    a_rst_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

endmodule

bind integer_literal_parser ilp_checker u_ilp_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_out_valid      (o_out.valid),
    .i_out_ready      (o_out.ready),
    .i_out_value      (o_out.value),
    .i_out_is_unsig   (o_out.is_unsig),
    .i_out_width_kind (o_out.width_kind),
    .i_out_err_code   (o_out.err_code)
);

// File: tb/tb_integer_literal_parser.sv
// Testbench for the integer literal parser: a directed table, then random literals checked by a predictor.
module tb_integer_literal_parser;
    timeunit 1ns;
    timeprecision 1ps;

    import ilp_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 8;
    localparam int HOLD_CYCLES  = 300;
    localparam int PHASE_CHARS  = 40;
    localparam int PRINT_CAP    = 100;

    // Scanner position inside one literal
    typedef enum logic [1:0] {
        SC_FIRST  = 2'd0,
        SC_ZERO   = 2'd1,
        SC_RUN    = 2'd2,
        SC_SUFFIX = 2'd3
    } t_scan;

    typedef struct packed {
        logic [63:0] value;
        logic        is_unsig;
        t_kind       kind;
        t_err        err;
    } t_parse_res;

    // One directed literal; res is used only when typed is set
    typedef struct {
        string      text;
        bit         wide;
        bit         typed;
        t_parse_res res;
    } t_row;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic i_cfg_wdata;

    ilp_in_if  in_if ();
    ilp_out_if out_if ();

    integer_literal_parser dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (in_if),
        .o_out       (out_if)
    );

    // Predictor state, one literal at a time
    bit          long_wide;
    t_scan       lit_scan;
    t_radix      lit_radix;
    logic [63:0] lit_acc;
    bit          lit_wide_ovf;
    bit          lit_bad;
    logic [6:0]  lit_run;
    bit          lit_u;
    bit          lit_z;
    logic [1:0]  lit_l;

    t_parse_res  pending_results[$];
    t_row        dir_rows[$];
    logic [7:0]  lit_chars[$];

    int tx_idle_pct;
    int rx_idle_pct;
    int hold_requests;
    int hold_served;
    int hold_left;
    int cycle_count;
    int mismatch_count;
    int chars_sent;
    int results_checked;
    int settings_written;
    int err_seen[3];

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // ---------------- predictor ----------------

    function automatic void restart_literal();
        lit_scan     = SC_FIRST;
        lit_radix    = RX_DEC;
        lit_acc      = '0;
        lit_wide_ovf = 1'b0;
        lit_bad      = 1'b0;
        lit_run      = '0;
        lit_u        = 1'b0;
        lit_z        = 1'b0;
        lit_l        = '0;
    endfunction

    // Hex digit value, 16 when not a hex digit
    function automatic int hex_digit(input logic [7:0] c);
        if (c >= "0" && c <= "9") return int'(c - "0");
        if (c >= "a" && c <= "f") return int'(c - "a") + 10;
        if (c >= "A" && c <= "F") return int'(c - "A") + 10;
        return 16;
    endfunction

    function automatic int radix_base(input t_radix r);
        case (r)
            RX_HEX:  return 16;
            RX_BIN:  return 2;
            RX_OCT:  return 8;
            default: return 10;
        endcase
    endfunction

    function automatic void suffix_step(input logic [7:0] c);
        if (c == "u" || c == "U") begin
            lit_u = 1'b1;
        end else if (c == "z" || c == "Z") begin
            lit_z = 1'b1;
        end else if ((c == "l" || c == "L") && lit_l < 2'd2) begin
            lit_l = lit_l + 2'd1;
        end
    endfunction

    function automatic void run_step(input logic [7:0] c);
        int          d;
        int          b;
        logic [67:0] prod;
        d = hex_digit(c);
        b = radix_base(lit_radix);
        if (d < 16) begin
            if (lit_run != 7'h7F) lit_run = lit_run + 7'd1;
            if (d >= b) begin
                lit_bad = 1'b1;
            end else if (!lit_bad && !lit_wide_ovf) begin
                prod = {4'b0, lit_acc} * 68'(b) + 68'(d);
                if (prod[67:64] != 4'b0) begin
                    lit_wide_ovf = 1'b1;
                    lit_acc      = '1;
                end else begin
                    lit_acc = prod[63:0];
                end
            end
        end else if (c == "'") begin
            if (lit_run != 7'h7F) lit_run = lit_run + 7'd1;
        end else begin
            lit_scan = SC_SUFFIX;
            suffix_step(c);
        end
    endfunction

    // Advance by one character; returns 1 with the result on the last one
    function automatic bit take_char(input logic [7:0] c, input logic lst,
                                     output t_parse_res res);
        t_kind       k;
        t_err        e;
        logic [63:0] maxv;
        res = '0;
        case (lit_scan)
            SC_FIRST: begin
                if (c == "0") begin
                    lit_radix = RX_OCT;
                    lit_run   = 7'd1;
                    lit_scan  = SC_ZERO;
                end else begin
                    lit_radix = RX_DEC;
                    lit_scan  = SC_RUN;
                    run_step(c);
                end
            end
            SC_ZERO: begin
                lit_scan = SC_RUN;
                if (c == "x" || c == "X") begin
                    lit_radix = RX_HEX;
                    lit_run   = '0;
                end else if (c == "b" || c == "B") begin
                    lit_radix = RX_BIN;
                    lit_run   = '0;
                end else begin
                    run_step(c);
                end
            end
            SC_RUN:  run_step(c);
            default: suffix_step(c);
        endcase
        if (!lst) return 1'b0;

        if (lit_l == 2'd1)      k = WK_LONG;
        else if (lit_l >= 2'd2) k = WK_LLONG;
        else if (lit_z)         k = WK_SIZE;
        else                    k = WK_INT;

        // Largest value of the chosen type
        if (lit_u) begin
            if (k == WK_INT)       maxv = U32_MAX;
            else if (k == WK_LONG) maxv = long_wide ? U64_MAX : U32_MAX;
            else                   maxv = U64_MAX;
        end else begin
            if (k == WK_INT)       maxv = S32_MAX;
            else if (k == WK_LONG) maxv = long_wide ? S64_MAX : S32_MAX;
            else                   maxv = S64_MAX;
        end

        // Run length wins over a bad digit, which wins over range
        if (int'(lit_run) >= MAX_RUN - 1)         e = ERR_OVF;
        else if (lit_bad)                         e = ERR_DIGIT;
        else if (lit_wide_ovf || lit_acc > maxv)  e = ERR_OVF;
        else                                      e = ERR_OK;

        res.value    = (e != ERR_OK) ? 64'd0 : lit_acc;
        res.is_unsig = lit_u;
        res.kind     = k;
        res.err      = e;
        restart_literal();
        return 1'b1;
    endfunction

    // ---------------- stimulus helpers ----------------

    function automatic string fill(input string s, input int n);
        string r;
        r = "";
        repeat (n) r = {r, s};
        return r;
    endfunction

    function automatic void add_row(input string text, input bit wide, input bit typed,
                                    input logic [63:0] v = '0, input bit u = 1'b0,
                                    input t_kind k = WK_INT, input t_err e = ERR_OK);
        t_row row;
        row.text           = text;
        row.wide           = wide;
        row.typed          = typed;
        row.res.value      = v;
        row.res.is_unsig   = u;
        row.res.kind       = k;
        row.res.err        = e;
        dir_rows.push_back(row);
    endfunction

    function automatic logic [7:0] digit_char(input int d);
        if (d < 10) return 8'("0" + d);
        return 8'(($urandom_range(1) ? "a" : "A") + d - 10);
    endfunction

    // Fill lit_chars with one random literal: mostly well formed, some broken, some noise
    task automatic build_random_literal();
        logic [63:0] v;
        logic [63:0] bb;
        logic [63:0] lims [4];
        logic [7:0]  digs[$];
        int          sel;
        int          b;
        int          n;
        int          p;
        t_radix      rx;
        string       suf_set;
        string       junk_set;
        lims     = '{S32_MAX, U32_MAX, S64_MAX, U64_MAX};
        suf_set  = "uUlLzZ";
        junk_set = "0123456789abcdefxXbB'uzl";
        lit_chars.delete();
        sel = $urandom_range(99);

        if (sel >= 85) begin
            n = $urandom_range(1, 6);
            repeat (n) lit_chars.push_back(8'($urandom_range(255)));
            return;
        end

        rx = t_radix'($urandom_range(3));
        if ($urandom_range(29) == 0) begin
            // Long decimal run around the run-length limit
            n = $urandom_range(94, 104);
            repeat (n) lit_chars.push_back(8'("0" + $urandom_range(1, 9)));
        end else begin
            case ($urandom_range(3))
                0:       v = lims[$urandom_range(3)] + $urandom_range(2) - 1;
                1:       v = {$urandom, $urandom} >> $urandom_range(63);
                2:       v = 64'($urandom_range(999));
                default: v = {$urandom, $urandom};
            endcase
            case (rx)
                RX_HEX: begin
                    lit_chars.push_back("0");
                    lit_chars.push_back($urandom_range(1) ? "x" : "X");
                end
                RX_BIN: begin
                    lit_chars.push_back("0");
                    lit_chars.push_back($urandom_range(1) ? "b" : "B");
                end
                RX_OCT:  lit_chars.push_back("0");
                default: ;
            endcase
            b  = radix_base(rx);
            bb = 64'(b);
            do begin
                digs.push_front(digit_char(int'(v % bb)));
                v = v / bb;
            end while (v != 0);
            // Extra digits push the value past 64 bits now and then
            if ($urandom_range(9) == 0) begin
                n = $urandom_range(1, 3);
                repeat (n) digs.push_back(digit_char($urandom_range(b - 1)));
            end
            foreach (digs[i]) begin
                lit_chars.push_back(digs[i]);
                if (i < digs.size() - 1 && $urandom_range(6) == 0) lit_chars.push_back("'");
            end
        end

        n = $urandom_range(3);
        repeat (n) lit_chars.push_back(suf_set[$urandom_range(5)]);

        // Broken literal: one character overwritten
        if (sel >= 70) begin
            p = $urandom_range(lit_chars.size() - 1);
            if ($urandom_range(1)) lit_chars[p] = 8'($urandom_range(255));
            else lit_chars[p] = junk_set[$urandom_range(junk_set.len() - 1)];
        end
    endtask

    // Send lit_chars one beat each; predicted or typed result queued on the last beat
    task automatic send_literal(input bit use_typed, input t_parse_res typed);
        t_parse_res res;
        logic       lst;
        for (int k = 0; k < lit_chars.size(); k++) begin
            while ($urandom_range(99) < tx_idle_pct) begin
                in_if.valid <= 1'b0;
                @(posedge i_clk);
            end
            lst = (k == lit_chars.size() - 1);
            in_if.valid <= 1'b1;
            in_if.ch    <= lit_chars[k];
            in_if.last  <= lst;
            do @(posedge i_clk); while (in_if.ready !== 1'b1);
            chars_sent++;
            if (take_char(lit_chars[k], lst, res)) begin
                pending_results.push_back(use_typed ? typed : res);
            end
        end
    endtask

    // Wait until every queued result is out and the pipeline has emptied
    task automatic drain_block();
        in_if.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_long_mode(input bit wide);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= wide;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        long_wide   = wide;
        settings_written++;
    endtask

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= PRINT_CAP) $display("MISMATCH at %0t: %s", $time, msg);
    endtask

    // ---------------- result side ----------------

    // Receiver: random stalls, plus a long hold-off on request
    initial out_if.ready = 1'b0;
    always @(posedge i_clk) begin
        if (hold_requests != hold_served) begin
            hold_served  <= hold_requests;
            hold_left    <= HOLD_CYCLES;
            out_if.ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left    <= hold_left - 1;
            out_if.ready <= 1'b0;
        end else begin
            out_if.ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Compare each result beat with the oldest pending literal
    always @(posedge i_clk) begin : check_results
        t_parse_res want;
        if (i_rst_n === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result beat with no literal pending");
            end else begin
                want = pending_results.pop_front();
                results_checked++;
                err_seen[want.err]++;
                if (out_if.value !== want.value)
                    report_mismatch($sformatf("value got %h want %h", out_if.value,
                                              want.value));
                if (out_if.is_unsig !== want.is_unsig)
                    report_mismatch($sformatf("is_unsig got %b want %b", out_if.is_unsig,
                                              want.is_unsig));
                if (out_if.width_kind !== want.kind)
                    report_mismatch($sformatf("width_kind got %0d want %0d",
                                              out_if.width_kind, want.kind));
                if (out_if.err_code !== want.err)
                    report_mismatch($sformatf("err_code got %0d want %0d",
                                              out_if.err_code, want.err));
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results outstanding", cycle_count,
                     pending_results.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    // ---------------- main sequence ----------------

    initial begin
        t_parse_res no_typed;
        int         phase_start;
        bit         wide;
        no_typed    = '0;
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_wdata = 1'b0;
        in_if.valid = 1'b0;
        in_if.ch    = 8'h00;
        in_if.last  = 1'b0;
        tx_idle_pct = 12;
        rx_idle_pct = 50;
        long_wide   = 1'b1;
        restart_literal();

        // Directed table: long is 64 bits (reset value) first, then 32 bits
        add_row("0", 1, 1, 64'd0, 0, WK_INT, ERR_OK);
        add_row("18446744073709551615ull", 1, 1, U64_MAX, 1, WK_LLONG, ERR_OK);
        add_row("18446744073709551616", 1, 1, 64'd0, 0, WK_INT, ERR_OVF);
        add_row("2147483647", 1, 1, S32_MAX, 0, WK_INT, ERR_OK);
        add_row("2147483648", 1, 1, 64'd0, 0, WK_INT, ERR_OVF);
        add_row("0xffffffffffffffffuz", 1, 1, U64_MAX, 1, WK_SIZE, ERR_OK);
        add_row("9223372036854775807L", 1, 1, S64_MAX, 0, WK_LONG, ERR_OK);
        add_row("0B2", 1, 1, 64'd0, 0, WK_INT, ERR_DIGIT);
        add_row("0b1b", 1, 1, 64'd0, 0, WK_INT, ERR_DIGIT);
        add_row("089", 1, 1, 64'd0, 0, WK_INT, ERR_DIGIT);
        add_row("0x", 1, 1, 64'd0, 0, WK_INT, ERR_OK);
        add_row(fill("0", 98), 1, 1, 64'd0, 0, WK_INT, ERR_OK);
        add_row(fill("0", 99), 1, 1, 64'd0, 0, WK_INT, ERR_OVF);
        add_row("0xFFFF'FFFF'ffff'FFFFULL", 1, 0);
        add_row("4294967295u", 1, 0);
        add_row("0b1011", 1, 0);
        add_row("0777", 1, 0);
        add_row("1'000'000", 1, 0);
        add_row({"0b", fill("'", 98), "2"}, 1, 0);
        add_row(fill("'", 130), 1, 0);
        add_row("1lLl", 1, 0);
        add_row("7Z", 1, 0);
        add_row("7zl", 1, 0);
        add_row("42 q", 1, 0);
        add_row("9\377u", 1, 0);
        add_row("u", 1, 0);
        add_row("2147483648l", 0, 1, 64'd0, 0, WK_LONG, ERR_OVF);
        add_row("4294967295ul", 0, 0);

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[r]) begin
            if (dir_rows[r].wide != long_wide) begin
                drain_block();
                set_long_mode(dir_rows[r].wide);
            end
            lit_chars.delete();
            for (int i = 0; i < dir_rows[r].text.len(); i++)
                lit_chars.push_back(dir_rows[r].text[i]);
            send_literal(dir_rows[r].typed, dir_rows[r].res);
        end

        // Random phases: three idle patterns, each with both long widths
        for (int ph = 0; ph < 6; ph++) begin
            drain_block();
            wide = !(ph % 4 == 1 || ph % 4 == 2);
            set_long_mode(wide);
            case (ph / 2)
                0:       begin tx_idle_pct = 12; rx_idle_pct = 50; end
                1:       begin tx_idle_pct = 50; rx_idle_pct = 12; end
                default: begin tx_idle_pct = 0;  rx_idle_pct = 0;  end
            endcase
            // Long receiver hold-off while the sender keeps pushing
            if (ph == 4) hold_requests <= hold_requests + 1;
            phase_start = chars_sent;
            while (chars_sent - phase_start < PHASE_CHARS) begin
                build_random_literal();
                send_literal(1'b0, no_typed);
            end
        end
        drain_block();

        $display("Checked %0d literals from %0d characters over %0d register writes",
                 results_checked, chars_sent, settings_written);
        $display("Results by code: ok %0d, bad digit %0d, overflow %0d; mismatches %0d",
                 err_seen[ERR_OK], err_seen[ERR_DIGIT], err_seen[ERR_OVF], mismatch_count);
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
